[hw/rtl/lplc_pkg.sv]
// Shared constants, types and helper functions of the length-prefixed label codec.
package lplc_pkg;

    localparam int SEG_MAX    = 32;
    localparam int BUF_DEPTH  = 32;
    localparam int LABEL_CAP  = (SEG_MAX < BUF_DEPTH) ? SEG_MAX : BUF_DEPTH;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int REM_W      = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 8;

    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] PREFIX_RESET = 8'd77;

    localparam logic [CFG_AW-1:0] REG_DECODE_MODE = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_PREFIX_CHAR = CFG_AW'(1);

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CUT   = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_FIRST,
        PH_PASS,
        PH_LEN1,
        PH_LEN2,
        PH_COPY,
        PH_DONE
    } t_dec_phase;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PRE,
        BK_TENS,
        BK_UNITS,
        BK_DATA,
        BK_TAIL
    } t_back_state;

    // One request from the front to the back: the store is done when it is taken, then the other parts in field order.
    typedef struct packed {
        logic              pre_en;
        logic [7:0]        pre_char;
        logic [1:0]        pre_err;
        logic              store_en;
        logic [BUF_AW-1:0] store_idx;
        logic [7:0]        store_char;
        logic              flush_en;
        logic [CNT_W-1:0]  flush_len;
        logic              flush_last;
        logic              tail_en;
        logic [7:0]        tail_char;
        logic              tail_valid;
        logic              tail_last;
        logic [1:0]        err;
    } t_cmd;

    function automatic logic [2:0] f_tens(input logic [CNT_W-1:0] len);
        logic [2:0] t;
        t = 3'd0;
        if (len >= CNT_W'(10)) t = 3'd1;
        if (len >= CNT_W'(20)) t = 3'd2;
        if (len >= CNT_W'(30)) t = 3'd3;
        if (len >= CNT_W'(40)) t = 3'd4;
        if (len >= CNT_W'(50)) t = 3'd5;
        if (len >= CNT_W'(60)) t = 3'd6;
        return t;
    endfunction

    function automatic logic [3:0] f_units(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] t10;
        t10 = CNT_W'({f_tens(len), 3'b000}) + CNT_W'({f_tens(len), 1'b0});
        return 4'(len - t10);
    endfunction

endpackage

[hw/rtl/lplc_if.sv]
// Handshake channel interfaces of the length-prefixed label codec.
interface lplc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, in_char, in_last, input ready);
    modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface lplc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_valid;
    logic       out_last;
    logic [1:0] out_error;

    modport source (output valid, out_char, out_valid, out_last, out_error, input ready);
    modport sink   (input valid, out_char, out_valid, out_last, out_error, output ready);
endinterface

interface lplc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lplc_pkg::CFG_AW-1:0] addr;
    logic [lplc_pkg::CFG_DW-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[hw/rtl/lplc_front.sv]
// Front part: accepts characters and register writes, classifies each character into a request.
module lplc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lplc_in_if.sink         i_in,
    lplc_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output lplc_pkg::t_cmd  o_cmd
);

    logic                            r_decode_mode;
    logic [7:0]                      r_prefix;
    logic [lplc_pkg::CNT_W-1:0]      r_label_count, n_label_count;
    logic                            r_at_start, n_at_start;
    lplc_pkg::t_dec_phase            r_phase, n_phase;
    logic [lplc_pkg::REM_W-1:0]      r_copy_rem, n_copy_rem;
    logic [1:0]                      r_digit_cnt, n_digit_cnt;
    logic                            r_first_done, n_first_done;
    logic [1:0]                      r_err, n_err;
    logic [7:0]                      r_first_char, n_first_char;

    logic                            w_accept;
    logic                            w_cfg_wr;
    logic                            w_cfg_hit;
    logic                            w_is_digit;
    logic [3:0]                      w_digit;
    logic [lplc_pkg::REM_W-1:0]      w_len2;
    logic [lplc_pkg::REM_W-1:0]      w_rem_dec;
    logic [7:0]                      w_c;
    logic                            w_last;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && !i_q_full;
    assign w_cfg_wr    = i_cfg.valid;
    assign w_cfg_hit   = (i_cfg.addr == lplc_pkg::REG_DECODE_MODE)
                      || (i_cfg.addr == lplc_pkg::REG_PREFIX_CHAR);
    assign w_c         = i_in.in_char;
    assign w_last      = i_in.in_last;
    assign w_is_digit  = (w_c >= lplc_pkg::CHAR_ZERO) && (w_c <= lplc_pkg::CHAR_NINE);
    assign w_digit     = 4'(w_c - lplc_pkg::CHAR_ZERO);
    assign w_len2      = lplc_pkg::REM_W'({r_copy_rem, 3'b000})
                       + lplc_pkg::REM_W'({r_copy_rem, 1'b0})
                       + lplc_pkg::REM_W'(w_digit);
    assign w_rem_dec   = (r_copy_rem != '0) ? r_copy_rem - 1'b1 : r_copy_rem;

    always_comb begin
        n_label_count = r_label_count;
        n_at_start    = r_at_start;
        n_phase       = r_phase;
        n_copy_rem    = r_copy_rem;
        n_digit_cnt   = r_digit_cnt;
        n_first_done  = r_first_done;
        n_err         = r_err;
        n_first_char  = r_first_char;
        o_cmd         = '0;
        o_push        = 1'b0;

        if (w_accept) begin
            o_push = 1'b1;
            if (!r_decode_mode) begin
                if (r_at_start) begin
                    o_cmd.pre_en   = 1'b1;
                    o_cmd.pre_char = r_prefix;
                    n_at_start     = 1'b0;
                end
                if (w_c == lplc_pkg::CHAR_DOT) begin
                    o_cmd.flush_en   = 1'b1;
                    o_cmd.flush_len  = r_label_count;
                    o_cmd.flush_last = 1'b0;
                    n_label_count    = '0;
                    if (w_last) begin
                        o_cmd.tail_en    = 1'b1;
                        o_cmd.tail_char  = lplc_pkg::CHAR_ZERO;
                        o_cmd.tail_valid = 1'b1;
                        o_cmd.tail_last  = 1'b1;
                    end
                end else begin
                    if (r_label_count < lplc_pkg::CNT_W'(lplc_pkg::LABEL_CAP)) begin
                        o_cmd.store_en   = 1'b1;
                        o_cmd.store_idx  = r_label_count[lplc_pkg::BUF_AW-1:0];
                        o_cmd.store_char = w_c;
                        n_label_count    = r_label_count + 1'b1;
                    end else if (r_err == lplc_pkg::ERR_NONE) begin
                        n_err = lplc_pkg::ERR_CUT;
                    end
                    if (w_last) begin
                        o_cmd.flush_en   = 1'b1;
                        o_cmd.flush_len  = n_label_count;
                        o_cmd.flush_last = 1'b1;
                    end
                end
            end else begin
                case (r_phase)
                    lplc_pkg::PH_PREFIX: begin
                        n_first_char = w_c;
                        if (w_last) begin
                            o_cmd.tail_en    = 1'b1;
                            o_cmd.tail_char  = w_c;
                            o_cmd.tail_valid = 1'b1;
                            o_cmd.tail_last  = 1'b1;
                        end else begin
                            n_phase = lplc_pkg::PH_FIRST;
                        end
                    end
                    lplc_pkg::PH_FIRST, lplc_pkg::PH_LEN1: begin
                        if (w_is_digit) begin
                            if (w_digit == 4'd0) begin
                                n_phase = lplc_pkg::PH_DONE;
                                if (w_last) begin
                                    o_cmd.tail_en   = 1'b1;
                                    o_cmd.tail_last = 1'b1;
                                end
                            end else if (w_last) begin
                                if (r_err == lplc_pkg::ERR_NONE) n_err = lplc_pkg::ERR_TRUNC;
                                o_cmd.tail_en   = 1'b1;
                                o_cmd.tail_last = 1'b1;
                            end else begin
                                n_copy_rem  = lplc_pkg::REM_W'(w_digit);
                                n_digit_cnt = 2'd1;
                                n_phase     = lplc_pkg::PH_LEN2;
                            end
                        end else if (r_phase == lplc_pkg::PH_FIRST) begin
                            o_cmd.pre_en     = 1'b1;
                            o_cmd.pre_char   = r_first_char;
                            o_cmd.tail_en    = 1'b1;
                            o_cmd.tail_char  = w_c;
                            o_cmd.tail_valid = 1'b1;
                            o_cmd.tail_last  = w_last;
                            n_phase          = lplc_pkg::PH_PASS;
                        end else begin
                            n_phase = lplc_pkg::PH_DONE;
                            if (w_last) begin
                                o_cmd.tail_en   = 1'b1;
                                o_cmd.tail_last = 1'b1;
                            end
                        end
                    end
                    lplc_pkg::PH_PASS: begin
                        o_cmd.tail_en    = 1'b1;
                        o_cmd.tail_char  = w_c;
                        o_cmd.tail_valid = 1'b1;
                        o_cmd.tail_last  = w_last;
                    end
                    lplc_pkg::PH_LEN2, lplc_pkg::PH_COPY: begin
                        if (r_phase == lplc_pkg::PH_LEN2 && w_is_digit) begin
                            n_digit_cnt = 2'd2;
                            if (w_len2 == '0) begin
                                n_phase = lplc_pkg::PH_DONE;
                                if (w_last) begin
                                    o_cmd.tail_en   = 1'b1;
                                    o_cmd.tail_last = 1'b1;
                                end
                            end else if (w_last) begin
                                if (r_err == lplc_pkg::ERR_NONE) n_err = lplc_pkg::ERR_TRUNC;
                                o_cmd.tail_en   = 1'b1;
                                o_cmd.tail_last = 1'b1;
                            end else begin
                                n_copy_rem = w_len2;
                                n_phase    = lplc_pkg::PH_COPY;
                            end
                        end else if (r_phase == lplc_pkg::PH_LEN2 && r_copy_rem == '0) begin
                            n_phase = lplc_pkg::PH_DONE;
                            if (w_last) begin
                                o_cmd.tail_en   = 1'b1;
                                o_cmd.tail_last = 1'b1;
                            end
                        end else begin
                            // copy one label character, dot first at the start of every label but the first
                            if (r_digit_cnt != 2'd0) begin
                                if (r_first_done) begin
                                    o_cmd.pre_en   = 1'b1;
                                    o_cmd.pre_char = lplc_pkg::CHAR_DOT;
                                end
                                n_first_done = 1'b1;
                                n_digit_cnt  = 2'd0;
                            end
                            n_copy_rem = w_rem_dec;
                            if (w_rem_dec == '0) begin
                                n_phase = lplc_pkg::PH_LEN1;
                            end else begin
                                n_phase = lplc_pkg::PH_COPY;
                                if (w_last && r_err == lplc_pkg::ERR_NONE) begin
                                    n_err = lplc_pkg::ERR_TRUNC;
                                end
                            end
                            o_cmd.tail_en    = 1'b1;
                            o_cmd.tail_char  = w_c;
                            o_cmd.tail_valid = 1'b1;
                            o_cmd.tail_last  = w_last;
                        end
                    end
                    default: begin
                        n_phase = lplc_pkg::PH_DONE;
                        if (w_last) begin
                            o_cmd.tail_en   = 1'b1;
                            o_cmd.tail_last = 1'b1;
                        end
                    end
                endcase
            end
            o_cmd.pre_err = r_err;
            o_cmd.err     = n_err;
            if (w_last) begin
                n_label_count = '0;
                n_at_start    = 1'b1;
                n_phase       = lplc_pkg::PH_PREFIX;
                n_copy_rem    = '0;
                n_digit_cnt   = 2'd0;
                n_first_done  = 1'b0;
                n_err         = lplc_pkg::ERR_NONE;
            end
        end

        // drop the name in progress on a write to the decode-mode or prefix register
        if (w_cfg_wr && w_cfg_hit) begin
            n_label_count = '0;
            n_at_start    = 1'b1;
            n_phase       = lplc_pkg::PH_PREFIX;
            n_copy_rem    = '0;
            n_digit_cnt   = 2'd0;
            n_first_done  = 1'b0;
            n_err         = lplc_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_prefix      <= lplc_pkg::PREFIX_RESET;
            r_label_count <= '0;
            r_at_start    <= 1'b1;
            r_phase       <= lplc_pkg::PH_PREFIX;
            r_copy_rem    <= '0;
            r_digit_cnt   <= 2'd0;
            r_first_done  <= 1'b0;
            r_err         <= lplc_pkg::ERR_NONE;
        end else begin
            if (w_cfg_wr && i_cfg.addr == lplc_pkg::REG_DECODE_MODE) begin
                r_decode_mode <= i_cfg.data[0];
            end
            if (w_cfg_wr && i_cfg.addr == lplc_pkg::REG_PREFIX_CHAR) begin
                r_prefix <= i_cfg.data[7:0];
            end
            r_label_count <= n_label_count;
            r_at_start    <= n_at_start;
            r_phase       <= n_phase;
            r_copy_rem    <= n_copy_rem;
            r_digit_cnt   <= n_digit_cnt;
            r_first_done  <= n_first_done;
            r_err         <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_char <= n_first_char;
    end

endmodule

[hw/rtl/lplc_queue.sv]
// Short request queue between the front and back parts.
module lplc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lplc_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lplc_pkg::t_cmd o_data
);

    lplc_pkg::t_cmd                 r_mem [lplc_pkg::QUEUE_DEPTH];
    logic [lplc_pkg::QUEUE_AW-1:0]  r_wr_ptr;
    logic [lplc_pkg::QUEUE_AW-1:0]  r_rd_ptr;
    logic [lplc_pkg::QUEUE_CW-1:0]  r_count;

    assign o_full  = (r_count == lplc_pkg::QUEUE_CW'(lplc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

[hw/rtl/lplc_back.sv]
// Back part: carries out requests, holds the label buffer and drives the output register.
module lplc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  lplc_pkg::t_cmd i_q_data,
    output logic           o_pop,
    lplc_out_if.source     o_out
);

    logic [7:0]                   r_buf [lplc_pkg::BUF_DEPTH];
    logic [7:0]                   r_rd_data;
    logic [lplc_pkg::BUF_AW-1:0]  r_rd_idx, n_rd_idx;
    lplc_pkg::t_back_state        r_state, n_state;
    lplc_pkg::t_cmd               r_cmd, n_cmd;

    logic                         r_out_valid;
    logic [7:0]                   r_out_char;
    logic                         r_out_ovalid;
    logic                         r_out_last;
    logic [1:0]                   r_out_err;

    logic                         w_fire;
    logic                         w_emit;
    logic [7:0]                   w_e_char;
    logic                         w_e_valid;
    logic                         w_e_last;
    logic [1:0]                   w_e_err;
    logic                         w_wr_en;
    logic                         w_data_end;

    function automatic lplc_pkg::t_back_state f_after_flush(input lplc_pkg::t_cmd c);
        return c.tail_en ? lplc_pkg::BK_TAIL : lplc_pkg::BK_IDLE;
    endfunction

    function automatic lplc_pkg::t_back_state f_after_pre(input lplc_pkg::t_cmd c);
        if (c.flush_en) begin
            return (c.flush_len > lplc_pkg::CNT_W'(9)) ? lplc_pkg::BK_TENS
                                                       : lplc_pkg::BK_UNITS;
        end
        return f_after_flush(c);
    endfunction

    assign w_fire     = !r_out_valid || o_out.ready;
    assign w_data_end = ({1'b0, r_rd_idx} == lplc_pkg::CNT_W'(r_cmd.flush_len - 1'b1));

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_rd_idx  = r_rd_idx;
        o_pop     = 1'b0;
        w_wr_en   = 1'b0;
        w_emit    = 1'b0;
        w_e_char  = 8'd0;
        w_e_valid = 1'b1;
        w_e_last  = 1'b0;
        w_e_err   = r_cmd.err;
        case (r_state)
            lplc_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_q_data;
                    n_rd_idx = '0;
                    w_wr_en  = i_q_data.store_en;
                    n_state  = i_q_data.pre_en ? lplc_pkg::BK_PRE : f_after_pre(i_q_data);
                end
            end
            lplc_pkg::BK_PRE: begin
                w_e_char = r_cmd.pre_char;
                w_e_err  = r_cmd.pre_err;
                if (w_fire) begin
                    w_emit  = 1'b1;
                    n_state = f_after_pre(r_cmd);
                end
            end
            lplc_pkg::BK_TENS: begin
                w_e_char = lplc_pkg::CHAR_ZERO + 8'(lplc_pkg::f_tens(r_cmd.flush_len));
                if (w_fire) begin
                    w_emit  = 1'b1;
                    n_state = lplc_pkg::BK_UNITS;
                end
            end
            lplc_pkg::BK_UNITS: begin
                w_e_char = lplc_pkg::CHAR_ZERO + 8'(lplc_pkg::f_units(r_cmd.flush_len));
                w_e_last = r_cmd.flush_last && (r_cmd.flush_len == '0);
                if (w_fire) begin
                    w_emit  = 1'b1;
                    n_state = (r_cmd.flush_len != '0) ? lplc_pkg::BK_DATA
                                                      : f_after_flush(r_cmd);
                end
            end
            lplc_pkg::BK_DATA: begin
                w_e_char = r_rd_data;
                w_e_last = r_cmd.flush_last && w_data_end;
                if (w_fire) begin
                    w_emit = 1'b1;
                    if (w_data_end) begin
                        n_state = f_after_flush(r_cmd);
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            lplc_pkg::BK_TAIL: begin
                w_e_char  = r_cmd.tail_char;
                w_e_valid = r_cmd.tail_valid;
                w_e_last  = r_cmd.tail_last;
                if (w_fire) begin
                    w_emit  = 1'b1;
                    n_state = lplc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lplc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lplc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit)           r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_rd_idx <= n_rd_idx;
        if (w_emit) begin
            r_out_char   <= w_e_char;
            r_out_ovalid <= w_e_valid;
            r_out_last   <= w_e_last;
            r_out_err    <= w_e_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_buf[i_q_data.store_idx] <= i_q_data.store_char;
        r_rd_data <= r_buf[n_rd_idx];
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.out_valid = r_out_ovalid;
    assign o_out.out_last  = r_out_last;
    assign o_out.out_error = r_out_err;

endmodule

[hw/rtl/length_prefixed_label_codec.sv]
// Top level of the length-prefixed label codec.
// Encodes a dotted name into a prefix character and length-prefixed labels, or decodes
// such a name back into dotted form, one input character per request. A front part
// takes one character per cycle, while the queue is not full, into a four-entry request
// queue; the back part takes a request only when done with the last one. A label in
// encode mode leaves in a burst of one or two digits plus its characters at the dot or
// the end of the name. Results leave through an output register, so the input keeps
// flowing into the queue while a result waits, until the queue is full. Labels longer
// than SEG_MAX (at most 32) are cut and flagged with error 1; a name that ends while
// decoding still owes characters is flagged with error 2. Writes to the decode-mode or
// prefix register drop the name in progress.
module length_prefixed_label_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lplc_in_if.sink    i_in,
    lplc_cfg_if.sink   i_cfg,
    lplc_out_if.source o_out
);

    lplc_pkg::t_cmd w_push_cmd;
    lplc_pkg::t_cmd w_pop_cmd;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    lplc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    lplc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_pop_cmd)
    );

    lplc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_pop_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
